// File: sv/ipcs_pkg.sv
// ipcs_pkg: shared types and constants for the inductance pulse capture sequencer
// holds the payload structs, event and phase codes, register indexes and reset values
// no dependencies
package ipcs_pkg;

  // field widths
  localparam int unsigned CmdW   = 4;
  localparam int unsigned PinsW  = 3;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned ClassW = 2;
  localparam int unsigned StatW  = 3;
  localparam int unsigned PfW    = 2;
  localparam int unsigned QcW    = 14;
  localparam int unsigned PwW    = 6;
  localparam int unsigned SpW    = 4;
  localparam int unsigned ToW    = 8;
  localparam int unsigned MsW    = 8;

  // capture depth default
  localparam int unsigned CaptureSamplesDef = 256;

  // event codes
  localparam logic [CmdW-1:0] CMD_START    = 4'd0;
  localparam logic [CmdW-1:0] CMD_MIDPULSE = 4'd1;
  localparam logic [CmdW-1:0] CMD_UPDATE   = 4'd2;
  localparam logic [CmdW-1:0] CMD_HALF     = 4'd3;
  localparam logic [CmdW-1:0] CMD_COMPLETE = 4'd4;
  localparam logic [CmdW-1:0] CMD_ERROR    = 4'd5;
  localparam logic [CmdW-1:0] CMD_OVERCUR  = 4'd6;
  localparam logic [CmdW-1:0] CMD_TICK     = 4'd7;
  localparam logic [CmdW-1:0] CMD_SAMPLE   = 4'd8;
  localparam logic [CmdW-1:0] CMD_SERVICE  = 4'd9;

  // phase codes
  localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
  localparam logic [PhaseW-1:0] PH_RISE     = 3'd1;
  localparam logic [PhaseW-1:0] PH_DECAY    = 3'd2;
  localparam logic [PhaseW-1:0] PH_COMPLETE = 3'd3;
  localparam logic [PhaseW-1:0] PH_FAULT    = 3'd4;

  // sample classes
  localparam logic [ClassW-1:0] CLS_RISE    = 2'd0;
  localparam logic [ClassW-1:0] CLS_DECAY   = 2'd1;
  localparam logic [ClassW-1:0] CLS_INVALID = 2'd2;

  // service outcomes
  localparam logic [StatW-1:0] STAT_NONE    = 3'd0;
  localparam logic [StatW-1:0] STAT_OK      = 3'd1;
  localparam logic [StatW-1:0] STAT_OVERCUR = 3'd2;
  localparam logic [StatW-1:0] STAT_TIMING  = 3'd3;
  localparam logic [StatW-1:0] STAT_OVERRUN = 3'd4;

  // pin fault codes
  localparam logic [PfW-1:0] PF_NONE      = 2'd0;
  localparam logic [PfW-1:0] PF_PRECHARGE = 2'd1;
  localparam logic [PfW-1:0] PF_MIDPULSE  = 2'd2;
  localparam logic [PfW-1:0] PF_FREEWHEEL = 2'd3;

  // expected gate readbacks
  localparam logic [PinsW-1:0] PINS_FREEWHEEL = 3'd6;
  localparam logic [PinsW-1:0] PINS_PULSE     = 3'd5;

  // register map
  localparam int unsigned AddrW = 5;
  localparam int unsigned IdxW  = 3;
  localparam logic [IdxW-1:0] REG_OFFSET = 3'd0;
  localparam logic [IdxW-1:0] REG_LIMIT  = 3'd1;
  localparam logic [IdxW-1:0] REG_PW     = 3'd2;
  localparam logic [IdxW-1:0] REG_SP     = 3'd3;
  localparam logic [IdxW-1:0] REG_TO     = 3'd4;

  // register reset values
  localparam logic [QcW-1:0] OFFSET_RST = 14'd8190;
  localparam logic [QcW-1:0] LIMIT_RST  = 14'd400;
  localparam logic [PwW-1:0] PW_RST     = 6'd60;
  localparam logic [SpW-1:0] SP_RST     = 4'd2;
  localparam logic [ToW-1:0] TO_RST     = 8'd5;

  // start guard: offset plus limit must stay below this
  localparam logic [QcW:0] QC_SUM_MAX = 15'd16380;

  // extreme codes
  localparam logic [CodeW-1:0] CODE_MAX = 12'd4095;
  localparam logic [MsW-1:0]   MS_SAT   = 8'd255;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [PinsW-1:0] gate_pins;
    logic [CodeW-1:0] adc_sample;
  } ipcs_in_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ClassW-1:0] sample_class;
    logic [StatW-1:0]  status;
    logic [PfW-1:0]    pin_fault_code;
    logic [CodeW-1:0]  min_code;
    logic [CodeW-1:0]  max_code;
    logic              result_ready;
  } ipcs_out_t;

endpackage

// File: sv/inductance_pulse_capture_sequencer.sv
// Inductance pulse capture sequencer. Every transaction on the input channel is one event
// (start, mid-pulse, pulse end, half capture, capture end, capture error, overcurrent,
// millisecond tick, ADC sample, service) and produces exactly one result transaction. The
// event is applied to the sequencer state in the cycle it is accepted and its result is
// registered into the result register, or into the skid register while it is held; one
// event can be taken every clock cycle while input ready is high. A two-entry output buffer
// (result register plus skid register) lets the input keep accepting while a result waits;
// input ready drops only when both entries are full. The critical path is the sample
// time-stamp product (count times sample period) and its compare against the pulse width.
// Registers are written through the APB-style port and should be changed only while no
// event is outstanding. Depends on ipcs_pkg.
module inductance_pulse_capture_sequencer
  import ipcs_pkg::*;
#(
  parameter int unsigned CAPTURE_SAMPLES = CaptureSamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // event channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ipcs_in_t            in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipcs_out_t           out_data_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CntW = $clog2(CAPTURE_SAMPLES + 1);
  localparam int unsigned TW   = CntW + SpW;
  localparam logic [CntW-1:0] CntMax = CntW'(CAPTURE_SAMPLES);

  // configuration registers
  logic [QcW-1:0] offset_q, limit_q;
  logic [PwW-1:0] pw_q;
  logic [SpW-1:0] sp_q;
  logic [ToW-1:0] to_q;

  // sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PfW-1:0]    pin_fault_q, pin_fault_d;
  logic              overrun_q, overrun_d;
  logic              overcur_q, overcur_d;
  logic              sample_over_q, sample_over_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [MsW-1:0]    elapsed_q, elapsed_d;
  logic [CodeW-1:0]  min_q, min_d, max_q, max_d;

  // output buffer
  logic      out_valid_q, skid_valid_q;
  ipcs_out_t out_q, skid_q;
  ipcs_out_t res;

  logic push, pop;
  logic [IdxW-1:0] widx;
  logic            cfg_wr;

  // apb register access
  assign pready = 1'b1;
  assign widx   = paddr[AddrW-1:2];
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      limit_q  <= LIMIT_RST;
      pw_q     <= PW_RST;
      sp_q     <= SP_RST;
      to_q     <= TO_RST;
    end else if (cfg_wr) begin
      case (widx)
        REG_OFFSET: offset_q <= pwdata[QcW-1:0];
        REG_LIMIT:  limit_q  <= pwdata[QcW-1:0];
        REG_PW:     pw_q     <= pwdata[PwW-1:0];
        REG_SP:     sp_q     <= pwdata[SpW-1:0];
        REG_TO:     to_q     <= pwdata[ToW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_OFFSET: prdata = {{(32-QcW){1'b0}}, offset_q};
      REG_LIMIT:  prdata = {{(32-QcW){1'b0}}, limit_q};
      REG_PW:     prdata = {{(32-PwW){1'b0}}, pw_q};
      REG_SP:     prdata = {{(32-SpW){1'b0}}, sp_q};
      REG_TO:     prdata = {{(32-ToW){1'b0}}, to_q};
      default:    prdata = 32'd0;
    endcase
  end

  // handshake
  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // event decode and state update
  logic            running, limits_ok, timed_out, oc;
  logic [CntW-1:0] cnt_inc;
  logic [TW-1:0]   t_stamp;
  logic [QcW-1:0]  q_code, dev;
  logic [QcW:0]    qc_sum;
  logic [PhaseW-1:0] svc_phase;

  assign running   = (phase_q == PH_RISE) || (phase_q == PH_DECAY);
  assign qc_sum    = {1'b0, offset_q} + {1'b0, limit_q};
  assign limits_ok = (offset_q > limit_q) && (qc_sum < QC_SUM_MAX);
  assign cnt_inc   = count_q + CntW'(1);
  assign t_stamp   = TW'(cnt_inc) * TW'(sp_q);
  assign q_code    = {in_data_i.adc_sample, 2'b00};
  assign dev       = (q_code >= offset_q) ? (q_code - offset_q) : (offset_q - q_code);
  assign timed_out = running && (elapsed_q > to_q);
  assign svc_phase = timed_out ? PH_FAULT : phase_q;
  assign oc        = overcur_q || ((svc_phase == PH_COMPLETE) && sample_over_q);

  always_comb begin
    phase_d       = phase_q;
    pin_fault_d   = pin_fault_q;
    overrun_d     = overrun_q;
    overcur_d     = overcur_q;
    sample_over_d = sample_over_q;
    count_d       = count_q;
    elapsed_d     = elapsed_q;
    min_d         = min_q;
    max_d         = max_q;
    res.sample_class = CLS_INVALID;
    res.status       = STAT_NONE;
    res.result_ready = 1'b0;

    case (in_data_i.command)
      CMD_START: begin
        if (phase_q == PH_IDLE && limits_ok) begin
          overrun_d     = 1'b0;
          overcur_d     = 1'b0;
          sample_over_d = 1'b0;
          count_d       = '0;
          elapsed_d     = '0;
          min_d         = CODE_MAX;
          max_d         = '0;
          if (in_data_i.gate_pins != PINS_FREEWHEEL) begin
            pin_fault_d = PF_PRECHARGE;
          end else begin
            pin_fault_d = PF_NONE;
            phase_d     = PH_RISE;
          end
        end
      end
      CMD_MIDPULSE: begin
        if (phase_q == PH_RISE && in_data_i.gate_pins != PINS_PULSE) begin
          pin_fault_d = PF_MIDPULSE;
          phase_d     = PH_FAULT;
        end
      end
      CMD_UPDATE: begin
        if (phase_q == PH_RISE) phase_d = PH_DECAY;
      end
      CMD_HALF: begin
        if (phase_q == PH_DECAY && in_data_i.gate_pins != PINS_FREEWHEEL) begin
          pin_fault_d = PF_FREEWHEEL;
          phase_d     = PH_FAULT;
        end
      end
      CMD_COMPLETE: begin
        if (phase_q == PH_DECAY) begin
          phase_d = PH_COMPLETE;
        end else begin
          overrun_d = 1'b1;
          phase_d   = PH_FAULT;
        end
      end
      CMD_ERROR: begin
        overrun_d = 1'b1;
        phase_d   = PH_FAULT;
      end
      CMD_OVERCUR: begin
        if (running) begin
          overcur_d = 1'b1;
          phase_d   = PH_FAULT;
        end
      end
      CMD_TICK: begin
        if (running && elapsed_q != MS_SAT) elapsed_d = elapsed_q + MsW'(1);
      end
      CMD_SAMPLE: begin
        if (running && count_q < CntMax) begin
          count_d = cnt_inc;
          // time stamp against pulse width; the boundary sample is invalid
          if (t_stamp < TW'(pw_q)) begin
            res.sample_class = CLS_RISE;
          end else if (t_stamp > TW'(pw_q)) begin
            res.sample_class = CLS_DECAY;
          end else begin
            res.sample_class = CLS_INVALID;
          end
          if (in_data_i.adc_sample < min_q) min_d = in_data_i.adc_sample;
          if (in_data_i.adc_sample > max_q) max_d = in_data_i.adc_sample;
          if (dev > limit_q) sample_over_d = 1'b1;
        end
      end
      CMD_SERVICE: begin
        phase_d = svc_phase;
        if (svc_phase == PH_COMPLETE || svc_phase == PH_FAULT) begin
          if (svc_phase == PH_COMPLETE && !oc) begin
            res.status = STAT_OK;
          end else if (oc) begin
            res.status = STAT_OVERCUR;
          end else if (pin_fault_q != PF_NONE) begin
            res.status = STAT_TIMING;
          end else begin
            res.status = STAT_OVERRUN;
          end
          res.result_ready = 1'b1;
          phase_d          = PH_IDLE;
        end
      end
      default: ;
    endcase

    res.phase          = phase_d;
    res.pin_fault_code = pin_fault_d;
    res.min_code       = min_d;
    res.max_code       = max_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      pin_fault_q   <= PF_NONE;
      overrun_q     <= 1'b0;
      overcur_q     <= 1'b0;
      sample_over_q <= 1'b0;
      count_q       <= '0;
      elapsed_q     <= '0;
      min_q         <= CODE_MAX;
      max_q         <= '0;
    end else if (push) begin
      phase_q       <= phase_d;
      pin_fault_q   <= pin_fault_d;
      overrun_q     <= overrun_d;
      overcur_q     <= overcur_d;
      sample_over_q <= sample_over_d;
      count_q       <= count_d;
      elapsed_q     <= elapsed_d;
      min_q         <= min_d;
      max_q         <= max_d;
    end
  end

  // output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

`ifndef SYNTHESIS
  // skid entry is only used behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while result register empty");

  // an outcome carries a status and only an outcome does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.status != STAT_NONE) == out_q.result_ready))
    else $error("status and result_ready disagree");

  // a finalized outcome leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.result_ready) |-> (out_q.phase == PH_IDLE))
    else $error("outcome reported outside idle");

  // an accepted event into an empty buffer shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_valid_q) |=> out_valid_q)
    else $error("accepted transaction lost");

  // extremes stay ordered once a sample is stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("min above max after stored sample");
`endif

endmodule
